[sv/hec_pkg.sv]
// ----------------------------------------------------------------------------
// hec_pkg
// Shared widths, reset values, register codes, sideband types and the
// arctangent table function for the hemisphere to equirect coordinate unit.
// ----------------------------------------------------------------------------
package hec_pkg;

  localparam int ANGLE_FRAC_BITS_DEF = 16;
  localparam int CORDIC_STEPS_DEF    = 18;

  localparam int PIX_W      = 12;
  localparam int OW_W       = 13;
  localparam int SW_W       = 14;
  localparam int COORD_W    = 21;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 14;

  localparam int AB_W    = 15;  // a, b
  localparam int PROD_W  = 28;  // A, B, X, F
  localparam int RAD_W   = 52;  // squared terms
  localparam int ROOT_W  = RAD_W / 2;
  localparam int CORD_W  = 44;  // cordic x, y
  localparam int NORM_TOP = 39; // leading one goes to this bit
  localparam int SHIFT_W = 6;

  localparam logic [OW_W-1:0]    OUT_WIDTH_RST  = 13'd1024;
  localparam logic [OW_W-1:0]    OUT_HEIGHT_RST = 13'd1024;
  localparam logic [SW_W-1:0]    SRC_WIDTH_RST  = 14'd4096;
  localparam logic [SW_W-1:0]    SRC_HEIGHT_RST = 14'd2048;
  localparam logic [COORD_W-1:0] COORD_MAX      = '1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_OUT_WIDTH  = 3'd0,
    CFG_OUT_HEIGHT = 3'd1,
    CFG_SRC_WIDTH  = 3'd2,
    CFG_SRC_HEIGHT = 3'd3,
    CFG_BACK_SIDE  = 3'd4
  } cfg_idx_t;

  typedef struct packed {
    logic                     deg;
    logic                     in_disc;
    logic signed [PROD_W-1:0] a_val;
    logic signed [PROD_W-1:0] b_val;
  } sq_tag_t;

  typedef struct packed {
    logic deg;
    logic pole;
    logic rim;
    logic a_pos;
    logic b_pos;
  } cd_tag_t;

  typedef struct packed {
    logic signed [PROD_W-1:0] y;
    logic signed [PROD_W-1:0] x;
  } cd_in_t;

  localparam real PI_R = 3.141592653589793;

  // atan(2^-i)/pi in half-turns, afb fraction bits, rounded half up
  function automatic longint atan_entry(int afb, int i);
    real    r;
    longint q;
    r = $atan(2.0 ** (-i)) / PI_R * (2.0 ** (afb + 1));
    q = longint'($floor(r));
    return (q + 64'sd1) >>> 1;
  endfunction

endpackage

[sv/hemisphere_to_equirect_coord_unit.sv]
// ----------------------------------------------------------------------------
// hemisphere_to_equirect_coord_unit
// Maps a reflection-face pixel to its Q13.8 source position in an
// equirectangular panorama.
// ----------------------------------------------------------------------------
// Fully pipelined: one transaction is accepted every clock while the output
// is not stalled. The datapath is built around the 26-stage square-root
// pipeline (one root bit per stage) and the CORDIC pipeline (five
// normalization stages plus one stage per iteration), with fixed-point front
// and back ends around them. A stall on the output while out_valid is high
// freezes the whole pipeline and holds in_stall high. Configuration
// registers may be written only while no transaction is in flight.
module hemisphere_to_equirect_coord_unit import hec_pkg::*; #(
  parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_BITS_DEF,
  parameter int CORDIC_STEPS    = CORDIC_STEPS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [PIX_W-1:0]      in_pix_x,
  input  logic [PIX_W-1:0]      in_pix_y,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [COORD_W-1:0]    out_src_u,
  output logic [COORD_W-1:0]    out_src_v,
  output logic                  out_coord_valid
);

  localparam int ZW    = ANGLE_FRAC_BITS + 3;
  localparam int NU_W  = ANGLE_FRAC_BITS + 2;
  localparam int PU_W  = NU_W + SW_W;
  localparam int NUM_W = PU_W + 9;
  localparam logic signed [ZW-1:0]   ONE_HT  = ZW'(longint'(1) <<< ANGLE_FRAC_BITS);
  localparam logic signed [ZW-1:0]   HALF_HT = ONE_HT >>> 1;
  localparam logic signed [ZW:0]     ONE_W   = (ZW+1)'(ONE_HT);
  localparam logic [NUM_W-1:0]       ONE_NUM = NUM_W'(longint'(1) << ANGLE_FRAC_BITS);

  // configuration
  logic [OW_W-1:0] out_width_r, out_height_r;
  logic [SW_W-1:0] src_width_r, src_height_r;
  logic            back_side_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_width_r  <= OUT_WIDTH_RST;
      out_height_r <= OUT_HEIGHT_RST;
      src_width_r  <= SRC_WIDTH_RST;
      src_height_r <= SRC_HEIGHT_RST;
      back_side_r  <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_OUT_WIDTH:  out_width_r  <= cfg_data[OW_W-1:0];
        CFG_OUT_HEIGHT: out_height_r <= cfg_data[OW_W-1:0];
        CFG_SRC_WIDTH:  src_width_r  <= cfg_data[SW_W-1:0];
        CFG_SRC_HEIGHT: src_height_r <= cfg_data[SW_W-1:0];
        CFG_BACK_SIDE:  back_side_r  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  logic run;
  logic out_valid_r;
  assign run      = !(out_valid_r && out_stall);
  assign in_stall = !run;

  logic [OW_W-1:0] d1, d2;
  assign d1 = out_width_r - 1'b1;
  assign d2 = out_height_r - 1'b1;

  // stage 1: disc numerators
  logic signed [AB_W-1:0] a1_r, b1_r, a1_nxt, b1_nxt;
  logic                   deg1_r, deg1_nxt, v1_r;

  always_comb begin
    a1_nxt   = $signed({2'b00, in_pix_x, 1'b0} - {2'b00, d1});
    b1_nxt   = $signed({2'b00, d2} - {2'b00, in_pix_y, 1'b0});
    deg1_nxt = (out_width_r < OW_W'(2)) || (out_height_r < OW_W'(2));
  end

  // stage 2: A, B, C
  logic signed [AB_W+OW_W:0] pa, pb;
  logic signed [PROD_W-1:0]  a2_r, b2_r;
  logic [2*OW_W-1:0]         c2_r, c2_nxt;
  logic                      deg2_r, v2_r;

  always_comb begin
    pa     = a1_r * $signed({1'b0, d2});
    pb     = b1_r * $signed({1'b0, d1});
    c2_nxt = d1 * d2;
  end

  // stage 3: squares
  logic signed [2*PROD_W-1:0] aa_f, bb_f;
  logic [RAD_W-1:0]           cc_f;
  logic [RAD_W-1:0]           aa3_r, bb3_r, cc3_r;
  logic signed [PROD_W-1:0]   a3_r, b3_r;
  logic                       deg3_r, v3_r;

  always_comb begin
    aa_f = a2_r * a2_r;
    bb_f = b2_r * b2_r;
    cc_f = c2_r * c2_r;
  end

  // stage 4: sum and F radicand
  logic [RAD_W:0]           sum4_r;
  logic [RAD_W-1:0]         fr4_r, cc4_r;
  logic signed [PROD_W-1:0] a4_r, b4_r;
  logic                     deg4_r, v4_r;

  // stage 5: disc test and X radicand
  logic [1:0][RAD_W-1:0] rad5_r;
  sq_tag_t               t5_r;
  logic                  v5_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else if (run) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (run) begin
      a1_r         <= a1_nxt;
      b1_r         <= b1_nxt;
      deg1_r       <= deg1_nxt;
      a2_r         <= pa[PROD_W-1:0];
      b2_r         <= pb[PROD_W-1:0];
      c2_r         <= c2_nxt;
      deg2_r       <= deg1_r;
      aa3_r        <= aa_f[RAD_W-1:0];
      bb3_r        <= bb_f[RAD_W-1:0];
      cc3_r        <= cc_f;
      a3_r         <= a2_r;
      b3_r         <= b2_r;
      deg3_r       <= deg2_r;
      sum4_r       <= {1'b0, aa3_r} + {1'b0, bb3_r};
      fr4_r        <= cc3_r - bb3_r;
      cc4_r        <= cc3_r;
      a4_r         <= a3_r;
      b4_r         <= b3_r;
      deg4_r       <= deg3_r;
      rad5_r[0]    <= cc4_r - sum4_r[RAD_W-1:0];
      rad5_r[1]    <= fr4_r;
      t5_r.deg     <= deg4_r;
      t5_r.in_disc <= sum4_r <= {1'b0, cc4_r};
      t5_r.a_val   <= a4_r;
      t5_r.b_val   <= b4_r;
    end
  end

  // square roots: lane 0 gives |X|, lane 1 gives F inside the disc
  logic                   sq_valid;
  logic [1:0][ROOT_W-1:0] root;
  sq_tag_t                sq_tag;

  hec_isqrt u_isqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (run),
    .in_valid  (v5_r),
    .rad       (rad5_r),
    .tag_in    (t5_r),
    .out_valid (sq_valid),
    .root      (root),
    .tag_out   (sq_tag)
  );

  // stage 6: forward component, pitch denominator, special cases
  cd_in_t [1:0]             vec6_r, vec6_nxt;
  cd_tag_t                  t6_r, t6_nxt;
  logic                     v6_r;
  logic signed [PROD_W-1:0] xm, abs_a;
  logic                     xzero;

  always_comb begin
    xm     = $signed({{(PROD_W-ROOT_W){1'b0}}, root[0]});
    abs_a  = sq_tag.a_val[PROD_W-1] ? -sq_tag.a_val : sq_tag.a_val;
    xzero  = !sq_tag.in_disc || (root[0] == '0);
    vec6_nxt[0].y = sq_tag.a_val;
    vec6_nxt[0].x = !sq_tag.in_disc ? '0 : (back_side_r ? -xm : xm);
    vec6_nxt[1].y = sq_tag.b_val;
    vec6_nxt[1].x = sq_tag.in_disc ? $signed({{(PROD_W-ROOT_W){1'b0}}, root[1]}) : abs_a;
    t6_nxt.deg    = sq_tag.deg;
    t6_nxt.pole   = xzero && (sq_tag.a_val == '0);
    t6_nxt.rim    = xzero && (sq_tag.a_val != '0);
    t6_nxt.a_pos  = !sq_tag.a_val[PROD_W-1] && (sq_tag.a_val != '0);
    t6_nxt.b_pos  = !sq_tag.b_val[PROD_W-1] && (sq_tag.b_val != '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v6_r <= 1'b0;
    end else if (run) begin
      v6_r <= sq_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (run) begin
      vec6_r <= vec6_nxt;
      t6_r   <= t6_nxt;
    end
  end

  // angles: lane 0 yaw = atan2(A, X), lane 1 pitch = atan2(B, F)
  logic               cd_valid;
  logic [1:0][ZW-1:0] ang;
  cd_tag_t            cd_tag;

  hec_cordic #(
    .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS),
    .CORDIC_STEPS    (CORDIC_STEPS)
  ) u_cordic (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (run),
    .in_valid  (v6_r),
    .vec       (vec6_r),
    .tag_in    (t6_r),
    .out_valid (cd_valid),
    .ang       (ang),
    .tag_out   (cd_tag)
  );

  // stage 7: pole and rim cases, wrap yaw, scale and clamp pitch
  logic signed [ZW-1:0] nu7_r, nv7_r, nu7_nxt, nv7_nxt;
  logic signed [ZW-1:0] zy, zp, yw;
  logic signed [ZW:0]   vw;
  logic                 deg7_r, v7_r;

  always_comb begin
    zy = $signed(ang[0]);
    zp = $signed(ang[1]);
    yw = cd_tag.rim ? (cd_tag.a_pos ? HALF_HT : -HALF_HT) : zy;
    vw = -($signed({zp[ZW-1], zp}) <<< 1);
    if (cd_tag.pole) begin
      nu7_nxt = '0;
      nv7_nxt = cd_tag.b_pos ? -ONE_HT : ONE_HT;
    end else begin
      if (yw > ONE_HT) begin
        nu7_nxt = yw - (ONE_HT <<< 1);
      end else if (yw < -ONE_HT) begin
        nu7_nxt = yw + (ONE_HT <<< 1);
      end else begin
        nu7_nxt = yw;
      end
      if (vw > ONE_W) begin
        nv7_nxt = ONE_HT;
      end else if (vw < -ONE_W) begin
        nv7_nxt = -ONE_HT;
      end else begin
        nv7_nxt = vw[ZW-1:0];
      end
    end
  end

  // stage 8: offset to [0, 2] and source spans
  logic [NU_W-1:0] nu8_r, nv8_r;
  logic [SW_W-1:0] spu8_r, spv8_r;
  logic            deg8_r, v8_r;
  logic signed [ZW-1:0] nu_off, nv_off;

  always_comb begin
    nu_off = nu7_r + ONE_HT;
    nv_off = nv7_r + ONE_HT;
  end

  // stage 9: scale by span
  logic [PU_W-1:0] pu9_r, pv9_r;
  logic            deg9_r, v9_r;

  // output register: round and saturate
  logic [NUM_W-1:0]   num_u, num_v, r_u, r_v;
  logic [COORD_W-1:0] out_src_u_r, out_src_v_r;
  logic [COORD_W-1:0] src_u_nxt, src_v_nxt;
  logic               out_coord_valid_r;

  always_comb begin
    num_u = {1'b0, pu9_r, 8'h00} + ONE_NUM;
    num_v = {1'b0, pv9_r, 8'h00} + ONE_NUM;
    r_u   = num_u >> (ANGLE_FRAC_BITS + 1);
    r_v   = num_v >> (ANGLE_FRAC_BITS + 1);
    src_u_nxt = (r_u > NUM_W'(COORD_MAX)) ? COORD_MAX : r_u[COORD_W-1:0];
    src_v_nxt = (r_v > NUM_W'(COORD_MAX)) ? COORD_MAX : r_v[COORD_W-1:0];
    if (deg9_r) begin
      src_u_nxt = '0;
      src_v_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v7_r        <= 1'b0;
      v8_r        <= 1'b0;
      v9_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (run) begin
      v7_r        <= cd_valid;
      v8_r        <= v7_r;
      v9_r        <= v8_r;
      out_valid_r <= v9_r;
    end
  end

  always_ff @(posedge clk) begin
    if (run) begin
      nu7_r             <= nu7_nxt;
      nv7_r             <= nv7_nxt;
      deg7_r            <= cd_tag.deg;
      nu8_r             <= nu_off[NU_W-1:0];
      nv8_r             <= nv_off[NU_W-1:0];
      spu8_r            <= (src_width_r == '0) ? '0 : src_width_r - 1'b1;
      spv8_r            <= (src_height_r == '0) ? '0 : src_height_r - 1'b1;
      deg8_r            <= deg7_r;
      pu9_r             <= nu8_r * spu8_r;
      pv9_r             <= nv8_r * spv8_r;
      deg9_r            <= deg8_r;
      out_src_u_r       <= src_u_nxt;
      out_src_v_r       <= src_v_nxt;
      out_coord_valid_r <= !deg9_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_src_u       = out_src_u_r;
  assign out_src_v       = out_src_v_r;
  assign out_coord_valid = out_coord_valid_r;

  // degenerate face results carry zero coordinates
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_coord_valid_r |-> out_src_u_r == '0 && out_src_v_r == '0)
    else $error("invalid coordinate with nonzero position");

  // face size below two pixels never yields a valid coordinate
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_width_r < OW_W'(2) || out_height_r < OW_W'(2))
      |-> !out_coord_valid_r)
    else $error("valid coordinate from degenerate face size");

  // reset empties the pipeline
  assert property (@(posedge clk) !rst_n |=> !out_valid_r && !v1_r && !v5_r)
    else $error("pipeline not empty after reset");

  // a frozen pipeline keeps its occupancy
  assert property (@(posedge clk) disable iff (!rst_n)
    !run |=> $stable(v5_r) && $stable(v9_r))
    else $error("stage valid moved during stall");

endmodule

[sv/hec_isqrt.sv]
// ----------------------------------------------------------------------------
// hec_isqrt
// Two-lane pipelined integer square root, one root bit per stage.
// ----------------------------------------------------------------------------
module hec_isqrt import hec_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   en,
  input  logic                   in_valid,
  input  logic [1:0][RAD_W-1:0]  rad,
  input  sq_tag_t                tag_in,
  output logic                   out_valid,
  output logic [1:0][ROOT_W-1:0] root,
  output sq_tag_t                tag_out
);

  localparam int REM_W = ROOT_W + 2;

  typedef struct packed {
    logic [RAD_W-1:0]  rad;
    logic [REM_W-1:0]  rem;
    logic [ROOT_W-1:0] root;
  } sq_lane_t;

  wire sq_lane_t [1:0] ln_s  [0:ROOT_W];
  wire                 vld_s [0:ROOT_W];
  wire sq_tag_t        tag_s [0:ROOT_W];

  for (genvar l = 0; l < 2; l++) begin : g_in
    assign ln_s[0][l] = '{rad: rad[l], rem: '0, root: '0};
  end
  assign vld_s[0] = in_valid;
  assign tag_s[0] = tag_in;

  for (genvar g = 0; g < ROOT_W; g++) begin : g_stage
    sq_lane_t [1:0] ln_r, ln_nxt;
    logic           vld_r;
    sq_tag_t        tag_r;

    always_comb begin
      logic [REM_W+1:0] cur;
      logic [REM_W+1:0] sub;
      for (int l = 0; l < 2; l++) begin
        cur = {ln_s[g][l].rem, ln_s[g][l].rad[RAD_W-1-2*g -: 2]};
        sub = {{(REM_W-ROOT_W){1'b0}}, ln_s[g][l].root, 2'b01};
        ln_nxt[l].rad = ln_s[g][l].rad;
        if (cur >= sub) begin
          ln_nxt[l].rem  = REM_W'(cur - sub);
          ln_nxt[l].root = {ln_s[g][l].root[ROOT_W-2:0], 1'b1};
        end else begin
          ln_nxt[l].rem  = REM_W'(cur);
          ln_nxt[l].root = {ln_s[g][l].root[ROOT_W-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r <= 1'b0;
      end else if (en) begin
        vld_r <= vld_s[g];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        ln_r  <= ln_nxt;
        tag_r <= tag_s[g];
      end
    end

    assign ln_s[g+1]  = ln_r;
    assign vld_s[g+1] = vld_r;
    assign tag_s[g+1] = tag_r;
  end

  assign out_valid = vld_s[ROOT_W];
  assign tag_out   = tag_s[ROOT_W];
  for (genvar l = 0; l < 2; l++) begin : g_out
    assign root[l] = ln_s[ROOT_W][l].root;
  end

endmodule

[sv/hec_cordic.sv]
// ----------------------------------------------------------------------------
// hec_cordic
// Two-lane pipelined vectoring CORDIC: atan2(y, x) in half-turns, with
// power-of-two input normalization ahead of the rotation stages.
// ----------------------------------------------------------------------------
module hec_cordic import hec_pkg::*; #(
  parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_BITS_DEF,
  parameter int CORDIC_STEPS    = CORDIC_STEPS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              en,
  input  logic                              in_valid,
  input  cd_in_t [1:0]                      vec,
  input  cd_tag_t                           tag_in,
  output logic                              out_valid,
  output logic [1:0][ANGLE_FRAC_BITS+2:0]   ang,
  output cd_tag_t                           tag_out
);

  localparam int ZW    = ANGLE_FRAC_BITS + 3;
  localparam int MSB_W = $clog2(PROD_W);
  localparam logic signed [ZW-1:0] ONE_HT = ZW'(longint'(1) <<< ANGLE_FRAC_BITS);

  typedef struct packed {
    logic signed [CORD_W-1:0] x;
    logic signed [CORD_W-1:0] y;
  } cd_vec_t;

  typedef struct packed {
    logic signed [CORD_W-1:0] x;
    logic signed [CORD_W-1:0] y;
    logic signed [ZW-1:0]     z;
  } cd_lane_t;

  cd_in_t  [1:0]              p1_r, p2_r, p3_r;
  logic    [1:0][PROD_W-1:0]  ax1_r, ay1_r, ax1_nxt, ay1_nxt;
  logic    [1:0][PROD_W-1:0]  m2_r, m2_nxt;
  logic    [1:0][SHIFT_W-1:0] s3_r, s3_nxt;
  cd_vec_t [1:0]              v4_r, v4_nxt;
  cd_lane_t [1:0]             l5_r, l5_nxt;
  logic                       vl1_r, vl2_r, vl3_r, vl4_r, vl5_r;
  cd_tag_t                    t1_r, t2_r, t3_r, t4_r, t5_r;

  always_comb begin
    logic [MSB_W-1:0] msb;
    for (int l = 0; l < 2; l++) begin
      ax1_nxt[l] = vec[l].x[PROD_W-1] ? PROD_W'(-vec[l].x) : PROD_W'(vec[l].x);
      ay1_nxt[l] = vec[l].y[PROD_W-1] ? PROD_W'(-vec[l].y) : PROD_W'(vec[l].y);
      m2_nxt[l]  = (ax1_r[l] > ay1_r[l]) ? ax1_r[l] : ay1_r[l];
      msb = '0;
      for (int k = 0; k < PROD_W; k++) begin
        if (m2_r[l][k]) msb = MSB_W'(k);
      end
      s3_nxt[l]   = SHIFT_W'(NORM_TOP) - SHIFT_W'(msb);
      v4_nxt[l].x = CORD_W'(p3_r[l].x) <<< s3_r[l];
      v4_nxt[l].y = CORD_W'(p3_r[l].y) <<< s3_r[l];
      if (v4_r[l].x[CORD_W-1]) begin
        l5_nxt[l].z = v4_r[l].y[CORD_W-1] ? -ONE_HT : ONE_HT;
        l5_nxt[l].x = -v4_r[l].x;
        l5_nxt[l].y = -v4_r[l].y;
      end else begin
        l5_nxt[l].z = '0;
        l5_nxt[l].x = v4_r[l].x;
        l5_nxt[l].y = v4_r[l].y;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vl1_r <= 1'b0;
      vl2_r <= 1'b0;
      vl3_r <= 1'b0;
      vl4_r <= 1'b0;
      vl5_r <= 1'b0;
    end else if (en) begin
      vl1_r <= in_valid;
      vl2_r <= vl1_r;
      vl3_r <= vl2_r;
      vl4_r <= vl3_r;
      vl5_r <= vl4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p1_r  <= vec;
      ax1_r <= ax1_nxt;
      ay1_r <= ay1_nxt;
      t1_r  <= tag_in;
      p2_r  <= p1_r;
      m2_r  <= m2_nxt;
      t2_r  <= t1_r;
      p3_r  <= p2_r;
      s3_r  <= s3_nxt;
      t3_r  <= t2_r;
      v4_r  <= v4_nxt;
      t4_r  <= t3_r;
      l5_r  <= l5_nxt;
      t5_r  <= t4_r;
    end
  end

  wire cd_lane_t [1:0] cs_s  [0:CORDIC_STEPS];
  wire                 vld_s [0:CORDIC_STEPS];
  wire cd_tag_t        tag_s [0:CORDIC_STEPS];

  assign cs_s[0]  = l5_r;
  assign vld_s[0] = vl5_r;
  assign tag_s[0] = t5_r;

  for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_step
    localparam logic signed [ZW-1:0] ROM_G = ZW'(atan_entry(ANGLE_FRAC_BITS, g));

    cd_lane_t [1:0] st_r, st_nxt;
    logic           vld_r;
    cd_tag_t        tag_r;

    always_comb begin
      for (int l = 0; l < 2; l++) begin
        if (!cs_s[g][l].y[CORD_W-1]) begin
          st_nxt[l].x = cs_s[g][l].x + (cs_s[g][l].y >>> g);
          st_nxt[l].y = cs_s[g][l].y - (cs_s[g][l].x >>> g);
          st_nxt[l].z = cs_s[g][l].z + ROM_G;
        end else begin
          st_nxt[l].x = cs_s[g][l].x - (cs_s[g][l].y >>> g);
          st_nxt[l].y = cs_s[g][l].y + (cs_s[g][l].x >>> g);
          st_nxt[l].z = cs_s[g][l].z - ROM_G;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r <= 1'b0;
      end else if (en) begin
        vld_r <= vld_s[g];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        st_r  <= st_nxt;
        tag_r <= tag_s[g];
      end
    end

    assign cs_s[g+1]  = st_r;
    assign vld_s[g+1] = vld_r;
    assign tag_s[g+1] = tag_r;
  end

  assign out_valid = vld_s[CORDIC_STEPS];
  assign tag_out   = tag_s[CORDIC_STEPS];
  for (genvar l = 0; l < 2; l++) begin : g_out
    assign ang[l] = cs_s[CORDIC_STEPS][l].z;
  end

endmodule

[verif/hemisphere_to_equirect_coord_unit_test.sv]
// ----------------------------------------------------------------------------
// hemisphere_to_equirect_coord_unit_test
// Self-checking bench: directed corner pixels (poles, rim, straight back,
// degenerate faces, tiny and large panoramas), then random pixels over several
// register settings with sender and receiver idling; every result is checked
// against a bit-exact integer model of the mapping.
// ----------------------------------------------------------------------------
module hemisphere_to_equirect_coord_unit_test;
  import hec_pkg::*;

  typedef struct {
    logic [COORD_W-1:0] u;
    logic [COORD_W-1:0] v;
    logic               cv;
  } coord_t;

  class coord_scoreboard;
    localparam longint ONE_HT = 64'sd1 <<< ANGLE_FRAC_BITS_DEF;
    localparam longint unsigned PI_Q60 = 64'h3243F6A8885A308D;
    int unsigned ow, oh, sw, sh;
    bit back;
    longint atan_tab[CORDIC_STEPS_DEF];
    coord_t pending[$];
    int errors;

    function new();
      longint unsigned sum, term, r, q;
      ow = OUT_WIDTH_RST;
      oh = OUT_HEIGHT_RST;
      sw = SRC_WIDTH_RST;
      sh = SRC_HEIGHT_RST;
      back = 0;
      errors = 0;
      for (int i = 0; i < CORDIC_STEPS_DEF; i++) begin
        if (i == 0) begin
          sum = PI_Q60 >> 2;
        end else begin
          sum = 0;
          for (int k = 0; (2 * k + 1) * i <= 60; k++) begin
            term = (64'd1 << (60 - (2 * k + 1) * i)) / (2 * k + 1);
            if (k & 1) sum -= term;
            else sum += term;
          end
        end
        r = sum;
        q = 0;
        for (int b = 0; b < ANGLE_FRAC_BITS_DEF + 1; b++) begin
          r = r << 1;
          q = q << 1;
          if (r >= PI_Q60) begin
            r -= PI_Q60;
            q |= 1;
          end
        end
        atan_tab[i] = longint'((q + 1) >> 1);
      end
    endfunction

    function void set_reg(cfg_idx_t idx, int unsigned val);
      case (idx)
        CFG_OUT_WIDTH:  ow = val & 13'h1FFF;
        CFG_OUT_HEIGHT: oh = val & 13'h1FFF;
        CFG_SRC_WIDTH:  sw = val & 14'h3FFF;
        CFG_SRC_HEIGHT: sh = val & 14'h3FFF;
        CFG_BACK_SIDE:  back = val[0];
        default: ;
      endcase
    endfunction

    function longint unsigned mag(longint val);
      return val < 0 ? longint'(-val) : val;
    endfunction

    function longint unsigned root(longint unsigned n);
      longint unsigned res, bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > n) bitv = bitv >> 2;
      while (bitv != 0) begin
        if (n >= res + bitv) begin
          n -= res + bitv;
          res = (res >> 1) + bitv;
        end else begin
          res = res >> 1;
        end
        bitv = bitv >> 2;
      end
      return res;
    endfunction

    function longint angle_of(longint y, longint x);
      longint unsigned m;
      longint z, xs, ys;
      int s;
      m = mag(x) > mag(y) ? mag(x) : mag(y);
      s = 0;
      z = 0;
      while (m < (64'd1 << 39) && s < 40) begin
        m = m << 1;
        s++;
      end
      x = x <<< s;
      y = y <<< s;
      if (x < 0) begin
        z = (y >= 0) ? ONE_HT : -ONE_HT;
        x = -x;
        y = -y;
      end
      for (int i = 0; i < CORDIC_STEPS_DEF; i++) begin
        xs = x >>> i;
        ys = y >>> i;
        if (y >= 0) begin
          x += ys;
          y -= xs;
          z += atan_tab[i];
        end else begin
          x -= ys;
          y += xs;
          z -= atan_tab[i];
        end
      end
      return z;
    endfunction

    function logic [COORD_W-1:0] to_pos(longint n, int unsigned size);
      longint unsigned span, num, res;
      span = size ? size - 1 : 0;
      num = longint'(n + ONE_HT) * span * 256 + ONE_HT;
      res = num / (2 * ONE_HT);
      return res > COORD_MAX ? COORD_MAX : res[COORD_W-1:0];
    endfunction

    function coord_t map_pixel(int unsigned px, int unsigned py);
      coord_t c;
      longint d1, d2, a, b, ca, cb, cc, xv, fv, yaw, v;
      longint unsigned sa, sb, sc;
      c.u = 0;
      c.v = 0;
      c.cv = 0;
      if (ow < 2 || oh < 2) return c;
      d1 = ow - 1;
      d2 = oh - 1;
      a = 2 * longint'(px) - d1;
      b = d2 - 2 * longint'(py);
      ca = a * d2;
      cb = b * d1;
      cc = d1 * d2;
      sa = mag(ca) * mag(ca);
      sb = mag(cb) * mag(cb);
      sc = cc * cc;
      xv = 0;
      if (sa + sb <= sc) begin
        xv = root(sc - sa - sb);
        if (back) xv = -xv;
        fv = root(sc - sb);
      end else begin
        fv = mag(ca);
      end
      if (xv == 0 && ca == 0) begin
        yaw = 0;
        v = (cb > 0) ? -ONE_HT : ONE_HT;
      end else begin
        if (xv != 0) yaw = angle_of(ca, xv);
        else yaw = (ca > 0) ? ONE_HT / 2 : -ONE_HT / 2;
        if (yaw > ONE_HT) yaw -= 2 * ONE_HT;
        if (yaw < -ONE_HT) yaw += 2 * ONE_HT;
        v = -2 * angle_of(cb, fv);
        if (v > ONE_HT) v = ONE_HT;
        if (v < -ONE_HT) v = -ONE_HT;
      end
      c.u = to_pos(yaw, sw);
      c.v = to_pos(v, sh);
      c.cv = 1;
      return c;
    endfunction

    function void note_input(int unsigned px, int unsigned py);
      pending.push_back(map_pixel(px, py));
    endfunction

    task report(string msg);
      $display("mismatch @%0t: %s", $time, msg);
      errors++;
    endtask

    task check_result(logic [COORD_W-1:0] u, logic [COORD_W-1:0] v, logic cv);
      coord_t e;
      if (pending.size() == 0) begin
        report($sformatf("unexpected transaction u=%0d v=%0d cv=%0b", u, v, cv));
      end else begin
        e = pending.pop_front();
        if (u !== e.u) report($sformatf("src_u %0d, expected %0d", u, e.u));
        if (v !== e.v) report($sformatf("src_v %0d, expected %0d", v, e.v));
        if (cv !== e.cv) report($sformatf("coord_valid %0b, expected %0b", cv, e.cv));
      end
    endtask
  endclass

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  in_valid;
  logic                  in_stall;
  logic [PIX_W-1:0]      in_pix_x;
  logic [PIX_W-1:0]      in_pix_y;
  logic                  out_valid;
  logic                  out_stall;
  logic [COORD_W-1:0]    out_src_u;
  logic [COORD_W-1:0]    out_src_v;
  logic                  out_coord_valid;

  coord_scoreboard sb;
  int idle_pct;
  int stall_pct;

  hemisphere_to_equirect_coord_unit uut (.*);

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  initial begin
    #(12 * 500000);
    $display("hemisphere_to_equirect_coord_unit_test: FAIL");
    $finish;
  end

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) sb.note_input(in_pix_x, in_pix_y);
    if (rst_n && out_valid && !out_stall)
      sb.check_result(out_src_u, out_src_v, out_coord_valid);
  end

  task apply_cfg(int unsigned ow, int unsigned oh, int unsigned sw, int unsigned sh,
                 int unsigned bk);
    int unsigned vals[5];
    vals = '{ow, oh, sw, sh, bk};
    for (int i = 0; i < 5; i++) begin
      cfg_we <= 1;
      cfg_index <= cfg_idx_t'(i);
      cfg_data <= CFG_DATA_W'(vals[i]);
      @(posedge clk);
      sb.set_reg(cfg_idx_t'(i), vals[i]);
    end
    cfg_we <= 0;
  endtask

  task send(int unsigned px, int unsigned py);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1;
    in_pix_x <= PIX_W'(px);
    in_pix_y <= PIX_W'(py);
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task drain();
    in_valid <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  task random_phase(int unsigned ow, int unsigned oh, int unsigned sw, int unsigned sh,
                    int unsigned bk, int mode);
    int unsigned px, py;
    apply_cfg(ow, oh, sw, sh, bk);
    idle_pct = (mode == 1) ? 55 : (mode == 3) ? 9 : 0;
    stall_pct = (mode == 2) ? 55 : (mode == 3) ? 9 : 0;
    for (int n = 0; n < 105; n++) begin
      if ($urandom_range(9) < 8) begin
        px = $urandom_range(ow - 1);
        py = $urandom_range(oh - 1);
      end else begin
        px = $urandom_range(4095);
        py = $urandom_range(4095);
      end
      send(px, py);
      if (mode == 2 && n == 60) drain();
    end
    drain();
  endtask

  initial begin
    sb = new();
    idle_pct = 0;
    stall_pct = 0;
    rst_n = 0;
    cfg_we = 0;
    cfg_index = CFG_OUT_WIDTH;
    cfg_data = 0;
    in_valid = 0;
    in_pix_x = 0;
    in_pix_y = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    apply_cfg(1025, 1025, 4096, 2048, 0);
    send(0, 0); send(4095, 4095); send(512, 0); send(512, 1024); send(512, 512);
    send(0, 512); send(1024, 512); send(4095, 0); send(0, 4095); send(700, 300);
    drain();
    apply_cfg(1025, 1025, 4096, 2048, 1);
    send(512, 512); send(512, 0); send(512, 1024); send(100, 900); send(1024, 1024);
    drain();
    apply_cfg(1, 1025, 0, 0, 0);
    send(5, 5); send(0, 0);
    drain();
    apply_cfg(2, 2, 0, 8192, 1);
    send(0, 0); send(1, 1); send(1, 0);
    drain();
    apply_cfg(4096, 4096, 8192, 1, 0);
    send(4095, 4095); send(2048, 0); send(0, 2048);
    drain();

    random_phase(1024, 1024, 4096, 2048, 0, 0);
    random_phase(640, 480, 1920, 960, 1, 1);
    random_phase(4096, 4096, 8192, 8192, 0, 2);
    random_phase(2, 2, 2, 2, 1, 3);
    random_phase(17, 9, 3, 8191, 0, 1);
    random_phase(1000, 1500, 4000, 2000, 1, 2);
    random_phase(333, 4095, 8192, 2, 0, 3);

    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("hemisphere_to_equirect_coord_unit_test: PASS");
    else
      $display("hemisphere_to_equirect_coord_unit_test: FAIL");
    $finish;
  end
endmodule

[sim.f]
sv/hec_pkg.sv
sv/hec_isqrt.sv
sv/hec_cordic.sv
sv/hemisphere_to_equirect_coord_unit.sv
verif/hemisphere_to_equirect_coord_unit_test.sv
